FILE: rtl/sacl_pkg.sv
// Shared types, constants and helpers of the set-associative tag lookup.
// No dependencies; sacl_rand, sacl_row_update and the top level import this package.
package sacl_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned WAYS_DEF       = 8;
    localparam int unsigned NUM_SETS_DEF   = 128;
    localparam int unsigned LINE_BYTES_DEF = 32;
    localparam int unsigned ADDR_BITS_DEF  = 32;

    // Fixed port widths
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned WAY_OUT_W  = 3;
    localparam int unsigned TAG_OUT_W  = 20;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned SEED_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd1;

    // Replacement policy codes
    localparam logic POLICY_LRU    = 1'b0;
    localparam logic POLICY_RANDOM = 1'b1;

    // Galois LFSR, right shifting, x^16+x^14+x^13+x^11+1
    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Outcome of one set lookup
    typedef struct packed {
        logic hit;
        logic evicted;
        logic need_rand;
    } lookup_flags_t;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] cur);
        logic [SEED_W-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0])
        begin
            nxt = nxt ^ LFSR_TAPS;
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/sacl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sacl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sacl_rand.sv
// Random victim unit: 16-bit LFSR, last random victim and the modulo-WAYS draw.
// Depends on sacl_pkg.
module sacl_rand #(
    parameter int unsigned WAYS = sacl_pkg::WAYS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_we,
    input  logic [sacl_pkg::SEED_W-1:0] seed,
    input  logic                        commit,
    output logic [$clog2(WAYS)-1:0]     victim
);
    import sacl_pkg::*;

    localparam int unsigned WAY_W = $clog2(WAYS);

    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic [WAY_W-1:0]  last_reg;
    logic [WAY_W-1:0]  last_next;

    logic [7:0]        pow_res [SEED_W];
    logic [WAY_W-1:0]  res_tab [256];

    logic [SEED_W-1:0] draw1;
    logic [SEED_W-1:0] draw2;
    logic [7:0]        sum1;
    logic [7:0]        sum2;
    logic [WAY_W-1:0]  pick1;
    logic [WAY_W-1:0]  pick2;
    logic              redraw;

    // Residues of 2^i mod WAYS, and a residue table for the folded sum
    for (genvar g = 0; g < SEED_W; g++)
    begin : g_pow
        localparam int unsigned PW = (32'd1 << g) % WAYS;
        assign pow_res[g] = 8'(PW);
    end

    for (genvar g = 0; g < 256; g++)
    begin : g_res
        localparam int unsigned RES = g % WAYS;
        assign res_tab[g] = WAY_W'(RES);
    end

    // Two candidate draws; mod WAYS by summing bit residues (at most 240)
    always_comb
    begin
        draw1 = lfsr_step(lfsr_reg);
        draw2 = lfsr_step(draw1);
        sum1  = '0;
        sum2  = '0;
        for (int i = 0; i < SEED_W; i++)
        begin
            sum1 = sum1 + (draw1[i] ? pow_res[i] : 8'd0);
            sum2 = sum2 + (draw2[i] ? pow_res[i] : 8'd0);
        end
        pick1  = res_tab[sum1];
        pick2  = res_tab[sum2];
        redraw = (pick1 == last_reg);
        victim = redraw ? pick2 : pick1;
    end

    // State update: seed write reloads, commit consumes the draw
    always_comb
    begin
        lfsr_next = lfsr_reg;
        last_next = last_reg;
        if (seed_we)
        begin
            lfsr_next = (seed == '0) ? SEED_W'(1) : seed;
        end
        else if (commit)
        begin
            lfsr_next = redraw ? draw2 : draw1;
            last_next = victim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_W'(1);
            last_reg <= '0;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
            last_reg <= last_next;
        end
    end

endmodule

FILE: rtl/sacl_row_update.sv
// Set row update: tag compare, victim choice, rank promotion, new row contents.
// Depends on sacl_pkg.
module sacl_row_update #(
    parameter int unsigned WAYS  = sacl_pkg::WAYS_DEF,
    parameter int unsigned TAG_W = 20
) (
    input  logic                                   policy,
    input  logic [TAG_W-1:0]                       tag,
    input  logic [$clog2(WAYS)-1:0]                rand_victim,
    input  logic [WAYS-1:0]                        row_valid,
    input  logic [WAYS-1:0][TAG_W-1:0]             row_tag,
    input  logic [WAYS-1:0][$clog2(WAYS)-1:0]      row_rank,
    output logic [WAYS-1:0]                        new_valid,
    output logic [WAYS-1:0][TAG_W-1:0]             new_tag,
    output logic [WAYS-1:0][$clog2(WAYS)-1:0]      new_rank,
    output logic [$clog2(WAYS)-1:0]                victim,
    output logic [TAG_W-1:0]                       old_tag,
    output sacl_pkg::lookup_flags_t                flags
);
    import sacl_pkg::*;

    localparam int unsigned WAY_W = $clog2(WAYS);

    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic             inv_found;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] lru_rank;
    logic [WAY_W-1:0] old_rank;
    logic             promote;

    // Lowest matching valid way, lowest invalid way, lowest-ranked way
    always_comb
    begin
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        lru_rank  = row_rank[0];
        for (int k = 0; k < WAYS; k++)
        begin
            if (!hit_found && row_valid[k] && row_tag[k] == tag)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(k);
            end
            if (!inv_found && !row_valid[k])
            begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(k);
            end
        end
        for (int k = 1; k < WAYS; k++)
        begin
            if (row_rank[k] < lru_rank)
            begin
                lru_way  = WAY_W'(k);
                lru_rank = row_rank[k];
            end
        end
    end

    // Victim and outcome
    always_comb
    begin
        if (hit_found)
        begin
            victim = hit_way;
        end
        else if (inv_found)
        begin
            victim = inv_way;
        end
        else if (policy == POLICY_RANDOM)
        begin
            victim = rand_victim;
        end
        else
        begin
            victim = lru_way;
        end
        flags.hit       = hit_found;
        flags.evicted   = !hit_found && !inv_found;
        flags.need_rand = !hit_found && !inv_found && (policy == POLICY_RANDOM);
        old_tag         = flags.evicted ? row_tag[victim] : '0;
        old_rank        = row_rank[victim];
        promote         = hit_found || (policy == POLICY_LRU);
    end

    // New row: fill on miss, promote on hit or LRU fill
    always_comb
    begin
        new_valid = row_valid;
        new_tag   = row_tag;
        new_rank  = row_rank;
        for (int k = 0; k < WAYS; k++)
        begin
            if (WAY_W'(k) == victim)
            begin
                new_valid[k] = 1'b1;
                if (!hit_found)
                begin
                    new_tag[k] = tag;
                end
                if (promote)
                begin
                    new_rank[k] = WAY_W'(WAYS - 1);
                end
            end
            else if (promote && row_rank[k] > old_rank)
            begin
                new_rank[k] = row_rank[k] - WAY_W'(1);
            end
        end
    end

endmodule

FILE: rtl/set_assoc_cache_tag_lookup.sv
// Set-associative tag lookup. The set row is read on the edge that accepts the address
// (ST_IDLE); in ST_LOOKUP the row is updated and written back, and rsp_valid is
// registered, once the output is not stalled. A new address is taken only back in
// ST_IDLE, after the read-modify-write of the set row in the single row RAM. After
// reset a clearing pass writes all 2^floor(log2(NUM_SETS)) set rows (128 by default)
// to zero with req_stall high; configuration writes are taken during it. Counters reset to zero.
module set_assoc_cache_tag_lookup #(
    parameter int unsigned WAYS       = sacl_pkg::WAYS_DEF,
    parameter int unsigned NUM_SETS   = sacl_pkg::NUM_SETS_DEF,
    parameter int unsigned LINE_BYTES = sacl_pkg::LINE_BYTES_DEF,
    parameter int unsigned ADDR_BITS  = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]     address,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]  way,
    output logic                            evicted,
    output logic [sacl_pkg::TAG_OUT_W-1:0]  evicted_tag,
    output logic [sacl_pkg::CNT_W-1:0]      hit_total,
    output logic [sacl_pkg::CNT_W-1:0]      access_total
);
    import sacl_pkg::*;

    localparam int unsigned WAY_W    = $clog2(WAYS);
    localparam int unsigned OFF_W    = $clog2(LINE_BYTES + 1) - 1;
    localparam int unsigned SET_W    = $clog2(NUM_SETS + 1) - 1;
    localparam int unsigned SET_CNT  = 1 << SET_W;
    localparam int unsigned LOW_W    = OFF_W + SET_W;
    localparam int unsigned EFF_ADDR = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int          TAG_RAW  = int'(EFF_ADDR) - int'(LOW_W);
    localparam int unsigned TAG_W    = (TAG_RAW < 1) ? 1 : TAG_RAW;
    localparam int unsigned TAG_BASE = WAYS;
    localparam int unsigned RANK_BASE = WAYS + WAYS * TAG_W;
    localparam int unsigned ROW_W    = WAYS * (1 + TAG_W + WAY_W);
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_ADDR);

    state_t state_reg;
    state_t state_next;

    logic [SET_W-1:0] clr_idx_reg;
    logic [SET_W-1:0] clr_idx_next;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             policy_reg;

    logic [ADDR_W-1:0] addr_masked;
    logic [SET_W-1:0]  req_set;
    logic [TAG_W-1:0]  req_tag;
    logic              req_accept;
    logic              out_load;

    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] new_row;

    logic [WAYS-1:0]             row_valid;
    logic [WAYS-1:0][TAG_W-1:0]  row_tag;
    logic [WAYS-1:0][WAY_W-1:0]  row_rank;
    logic [WAYS-1:0]             upd_valid;
    logic [WAYS-1:0][TAG_W-1:0]  upd_tag;
    logic [WAYS-1:0][WAY_W-1:0]  upd_rank;
    logic [WAY_W-1:0]            upd_victim;
    logic [TAG_W-1:0]            upd_old_tag;
    lookup_flags_t               upd_flags;
    logic [WAY_W-1:0]            rand_victim;
    logic                        rand_commit;

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 hit_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    logic                 evicted_reg;
    logic [TAG_OUT_W-1:0] evicted_tag_reg;
    logic [CNT_W-1:0]     hit_cnt_reg;
    logic [CNT_W-1:0]     hit_cnt_next;
    logic [CNT_W-1:0]     acc_cnt_reg;
    logic [CNT_W-1:0]     acc_cnt_next;

    // Address split
    assign addr_masked = address & ADDR_MASK;
    assign req_set     = SET_W'(addr_masked >> OFF_W);
    assign req_tag     = TAG_W'(addr_masked >> LOW_W);
    assign req_accept  = req_valid && !req_stall;

    // Row RAM: valid bits, tags, ranks of all ways of one set
    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_CNT)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (req_set),
        .rdata (ram_rdata)
    );

    // Row unpack and pack
    always_comb
    begin
        row_valid = ram_rdata[WAYS-1:0];
        for (int k = 0; k < WAYS; k++)
        begin
            row_tag[k]  = ram_rdata[TAG_BASE + k * TAG_W +: TAG_W];
            row_rank[k] = ram_rdata[RANK_BASE + k * WAY_W +: WAY_W];
        end
        new_row = '0;
        new_row[WAYS-1:0] = upd_valid;
        for (int k = 0; k < WAYS; k++)
        begin
            new_row[TAG_BASE + k * TAG_W +: TAG_W]   = upd_tag[k];
            new_row[RANK_BASE + k * WAY_W +: WAY_W]  = upd_rank[k];
        end
    end

    sacl_row_update #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_row_update (
        .policy      (policy_reg),
        .tag         (tag_reg),
        .rand_victim (rand_victim),
        .row_valid   (row_valid),
        .row_tag     (row_tag),
        .row_rank    (row_rank),
        .new_valid   (upd_valid),
        .new_tag     (upd_tag),
        .new_rank    (upd_rank),
        .victim      (upd_victim),
        .old_tag     (upd_old_tag),
        .flags       (upd_flags)
    );

    assign rand_commit = out_load && upd_flags.need_rand;

    sacl_rand #(
        .WAYS (WAYS)
    ) u_rand (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed_we (cfg_we && cfg_index == CFG_SEED),
        .seed    (cfg_data),
        .commit  (rand_commit),
        .victim  (rand_victim)
    );

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(SET_CNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req_stall = 1'b1;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = new_row;
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                ram_re    = req_valid;
            end
            ST_LOOKUP:
            begin
                out_load = !rsp_valid_reg || !rsp_stall;
                ram_we   = out_load;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Response valid and counters
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        hit_cnt_next   = hit_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
            if (acc_cnt_reg != '1)
            begin
                acc_cnt_next = acc_cnt_reg + CNT_W'(1);
            end
            if (upd_flags.hit && hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            policy_reg    <= POLICY_LRU;
            rsp_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            if (cfg_we && cfg_index == CFG_POLICY)
            begin
                policy_reg <= cfg_data[0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            set_reg <= req_set;
            tag_reg <= req_tag;
        end
        if (out_load)
        begin
            hit_reg         <= upd_flags.hit;
            way_reg         <= WAY_OUT_W'(upd_victim);
            evicted_reg     <= upd_flags.evicted;
            evicted_tag_reg <= TAG_OUT_W'(upd_old_tag);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign way          = way_reg;
    assign evicted      = evicted_reg;
    assign evicted_tag  = evicted_tag_reg;
    assign hit_total    = hit_cnt_reg;
    assign access_total = acc_cnt_reg;

    // A new response only comes out of the lookup cycle
    a_rsp_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("response raised outside lookup");

    // Hits never exceed accesses
    a_hits_le_access: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= acc_cnt_reg)
        else $error("hit count above access count");

    // Row RAM is never written while idle, so no write races a read of the same set
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("row write in idle state");

    // Each delivered lookup counts one access
    a_access_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && acc_cnt_reg != '1) |=> acc_cnt_reg == $past(acc_cnt_reg) + CNT_W'(1))
        else $error("access count did not advance");

    // No address is taken during the clearing pass
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(req_accept))
        else $error("address accepted while clearing");

endmodule
